// ----- design/jezc_pkg.sv -----
// ----------------------------------------------------------------------------
// jezc_pkg
// Shared types, constants and fixed-point helpers of the zero-crossing core.
// ----------------------------------------------------------------------------
package jezc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [30:0] STEP_SIZE_RESET     = 31'd16777216;
    localparam logic [31:0] INITIAL_SLOPE_RESET = 32'd16777216;
    localparam logic [7:0]  MAX_POINTS_RESET    = 8'd100;

    localparam int FRAC_BITS = 24;

    typedef enum logic [1:0] {
        REG_STEP_SIZE     = 2'd0,
        REG_INITIAL_SLOPE = 2'd1,
        REG_MAX_POINTS    = 2'd2
    } cfg_index_t;

    // one queued grid step, coefficient p already fixed for zero
    typedef struct packed {
        logic               start;
        logic signed [31:0] grid_x;
        logic               p_neg;
        logic [31:0]        p_mag;
        logic signed [31:0] q;
    } step_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_Q,
        ST_SAT_M,
        ST_MUL_U,
        ST_DIV_GO,
        ST_TRUNC_U,
        ST_DIV_WAIT,
        ST_CROSS,
        ST_DIV2_GO,
        ST_DIV2_WAIT,
        ST_FINISH
    } back_state_t;

    // product / 2^24, truncating toward zero
    function automatic logic signed [39:0] trunc_q24(input logic signed [63:0] v);
        logic signed [63:0] adj;
        adj = v[63] ? v + 64'sd16777215 : v;
        return adj[63:FRAC_BITS];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- design/jezc_front.sv -----
// ----------------------------------------------------------------------------
// jezc_front
// Accepts grid steps, classifies the P coefficient and queues them for the back.
// ----------------------------------------------------------------------------
module jezc_front import jezc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_start_req,
    input  logic signed [31:0] s_grid_x,
    input  logic signed [31:0] s_midpoint_p,
    input  logic signed [31:0] s_midpoint_q,
    output logic               item_valid,
    output step_item_t         item,
    input  logic               item_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    step_item_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    step_item_t       cls;
    logic signed [31:0] p_fix;

    always_comb begin
        p_fix      = (s_midpoint_p == 32'sd0) ? 32'sd1 : s_midpoint_p;
        cls.start  = s_start_req;
        cls.grid_x = s_grid_x;
        cls.p_neg  = p_fix[31];
        cls.p_mag  = p_fix[31] ? 32'(-p_fix) : 32'(p_fix);
        cls.q      = s_midpoint_q;
    end

    assign s_ready    = (cnt_reg != FULL_CNT);
    assign push       = s_valid && s_ready;
    assign item_valid = (cnt_reg != '0);
    assign item       = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (item_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !item_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && item_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= cls;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        item_pop |-> item_valid) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !item_pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

// ----- design/jezc_div.sv -----
// ----------------------------------------------------------------------------
// jezc_div
// Radix-2 restoring divider, unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jezc_div import jezc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] dsr_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [33:0] diff;

    assign trial = {rem_reg, quo_reg[63]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[33]) begin
                rem_next = diff[32:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/jezc_back.sv -----
// ----------------------------------------------------------------------------
// jezc_back
// Step sequencer: Euler update, sign-change check and crossing interpolation.
// ----------------------------------------------------------------------------
module jezc_back import jezc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [30:0]        step_size,
    input  logic signed [31:0] initial_slope,
    input  logic [7:0]         max_points,
    input  logic               item_valid,
    input  step_item_t         item,
    output logic               item_pop,
    output logic               div_start,
    input  logic               div_busy,
    input  logic               div_done,
    output logic [63:0]        div_dividend,
    output logic [32:0]        div_divisor,
    input  logic [63:0]        div_quotient,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_u_next,
    output logic signed [31:0] m_slope_next,
    output logic               m_crossing_found,
    output logic signed [31:0] m_crossing_x,
    output logic [7:0]         m_points_found
);

    back_state_t state_reg, state_next;

    logic signed [31:0] u_reg, slope_reg;
    logic [7:0]         count_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] m_coef_reg;
    logic signed [39:0] t_reg;
    logic signed [31:0] u_new_reg, s_new_reg, cx_reg;
    logic               found_reg;
    logic [32:0]        apb_reg;
    logic               out_valid_reg;
    logic               term_neg_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [31:0]        a_mag, b_mag;
    logic               sign_change;
    logic               load_out;
    logic [63:0]        prod_mag;
    logic signed [64:0] term;

    assign a_mag = u_reg[31] ? 32'(-u_reg) : 32'(u_reg);
    assign b_mag = u_new_reg[31] ? 32'(-u_new_reg) : 32'(u_new_reg);
    assign sign_change = ((u_reg < 0) && (u_new_reg > 0)) || ((u_reg > 0) && (u_new_reg < 0));
    assign prod_mag = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || m_ready);
    assign term = term_neg_reg ? -$signed({1'b0, div_quotient})
                               : $signed({1'b0, div_quotient});

    // shared multiplier operand select
    always_comb begin
        mul_a = $signed({2'b00, step_size});
        mul_b = {item.q[31], item.q};
        case (state_reg)
            ST_MUL_U: begin
                mul_a = {m_coef_reg[31], m_coef_reg};
                mul_b = {u_reg[31], u_reg};
            end
            ST_DIV_GO: mul_b = {slope_reg[31], slope_reg};
            ST_CROSS:  mul_b = $signed({1'b0, a_mag});
            default:   mul_b = {item.q[31], item.q};
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb begin
        state_next   = state_reg;
        item_pop     = 1'b0;
        div_start    = 1'b0;
        div_dividend = prod_mag;
        div_divisor  = {1'b0, item.p_mag};
        unique case (state_reg)
            ST_IDLE:    if (item_valid) state_next = ST_MUL_Q;
            ST_MUL_Q:   state_next = ST_SAT_M;
            ST_SAT_M:   state_next = ST_MUL_U;
            ST_MUL_U:   state_next = ST_DIV_GO;
            ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = ST_TRUNC_U;
            end
            ST_TRUNC_U: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (div_done) state_next = ST_CROSS;
            ST_CROSS: begin
                if (sign_change && (count_reg < max_points)) begin
                    state_next = ST_DIV2_GO;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV2_GO: begin
                div_start    = 1'b1;
                div_dividend = 64'(prod_reg);
                div_divisor  = apb_reg;
                state_next   = ST_DIV2_WAIT;
            end
            ST_DIV2_WAIT: if (div_done) state_next = ST_FINISH;
            ST_FINISH: begin
                if (load_out) begin
                    item_pop   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            u_reg         <= '0;
            slope_reg     <= INITIAL_SLOPE_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && item_valid && item.start) begin
                u_reg     <= '0;
                slope_reg <= initial_slope;
                count_reg <= '0;
            end
            if (state_reg == ST_CROSS) begin
                found_reg <= sign_change && (count_reg < max_points);
            end
            if (load_out) begin
                u_reg     <= u_new_reg;
                slope_reg <= s_new_reg;
                count_reg <= count_reg + {7'd0, found_reg};
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p[63:0];
        case (state_reg)
            ST_SAT_M:   m_coef_reg <= sat32(66'(trunc_q24(prod_reg)));
            // sign of m*u over p, kept while prod_reg is reused
            ST_DIV_GO:  term_neg_reg <= prod_reg[63] ^ item.p_neg;
            ST_TRUNC_U: t_reg <= trunc_q24(prod_reg);
            ST_DIV_WAIT: begin
                u_new_reg <= sat32(66'(u_reg) + 66'(t_reg));
                s_new_reg <= sat32(66'(slope_reg) + 66'(term));
                cx_reg    <= '0;
            end
            ST_CROSS:   apb_reg <= {1'b0, a_mag} + {1'b0, b_mag};
            ST_DIV2_WAIT: begin
                cx_reg <= sat32(66'(item.grid_x) + $signed({2'b00, div_quotient}));
            end
            default: ;
        endcase
        if (load_out) begin
            m_u_next         <= u_new_reg;
            m_slope_next     <= s_new_reg;
            m_crossing_found <= found_reg;
            m_crossing_x     <= found_reg ? cx_reg : 32'sd0;
            m_points_found   <= count_reg + {7'd0, found_reg};
        end
    end

    assign m_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy) else $error("divider restarted while busy");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && found_reg |=> count_reg == $past(count_reg) + 1'b1)
        else $error("crossing not counted");
`endif

endmodule

// ----- design/jacobi_equation_zero_crossing_core.sv -----
// ----------------------------------------------------------------------------
// jacobi_equation_zero_crossing_core
// Euler integrator of the Jacobi equation with conjugate point detection.
//
//   channel  dir  handshake         payload
//   s_       in   s_valid/s_ready   start_req, grid_x, midpoint_p, midpoint_q
//   m_       out  m_valid/m_ready   u_next, slope_next, crossing_found,
//                                   crossing_x, points_found
//   cfg_     in   cfg_wr_en         cfg_index, cfg_wr_data
//
// A step runs one division on the shared radix-2 divider, and two when
// a crossing is interpolated.
// Synchronous active-low reset, no clearing pass.
// The input queue keeps accepting, until full, while a result waits on m_ready.
// ----------------------------------------------------------------------------
module jacobi_equation_zero_crossing_core import jezc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_start_req,
    input  logic signed [31:0] s_grid_x,
    input  logic signed [31:0] s_midpoint_p,
    input  logic signed [31:0] s_midpoint_q,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_u_next,
    output logic signed [31:0] m_slope_next,
    output logic               m_crossing_found,
    output logic signed [31:0] m_crossing_x,
    output logic [7:0]         m_points_found
);

    logic [30:0]        step_size_reg;
    logic signed [31:0] initial_slope_reg;
    logic [7:0]         max_points_reg;

    logic        item_valid;
    step_item_t  item;
    logic        item_pop;
    logic        div_start;
    logic        div_busy;
    logic        div_done;
    logic [63:0] div_dividend;
    logic [32:0] div_divisor;
    logic [63:0] div_quotient;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg     <= STEP_SIZE_RESET;
            initial_slope_reg <= INITIAL_SLOPE_RESET;
            max_points_reg    <= MAX_POINTS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STEP_SIZE:     step_size_reg     <= cfg_wr_data[30:0];
                REG_INITIAL_SLOPE: initial_slope_reg <= cfg_wr_data;
                REG_MAX_POINTS:    max_points_reg    <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    jezc_front #(.DEPTH(DEPTH)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_req  (s_start_req),
        .s_grid_x     (s_grid_x),
        .s_midpoint_p (s_midpoint_p),
        .s_midpoint_q (s_midpoint_q),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop)
    );

    jezc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    jezc_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step_size        (step_size_reg),
        .initial_slope    (initial_slope_reg),
        .max_points       (max_points_reg),
        .item_valid       (item_valid),
        .item             (item),
        .item_pop         (item_pop),
        .div_start        (div_start),
        .div_busy         (div_busy),
        .div_done         (div_done),
        .div_dividend     (div_dividend),
        .div_divisor      (div_divisor),
        .div_quotient     (div_quotient),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_u_next         (m_u_next),
        .m_slope_next     (m_slope_next),
        .m_crossing_found (m_crossing_found),
        .m_crossing_x     (m_crossing_x),
        .m_points_found   (m_points_found)
    );

endmodule
